// File: rtl/brq_pkg.sv
`timescale 1ns / 1ps

package brq_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int TICK_W   = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam int IN_TICK_W = 16;
  localparam logic [IN_TICK_W-1:0] TICK_MAX = IN_TICK_W'((64'd1 << TICK_W) - 64'd1);

  // Request codes
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_WAIT = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_BUSY    = 3'd4;

  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(CAPACITY);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] push_word;
    logic [15:0] wait_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  reply_to;
    logic [2:0]  status;
    logic [31:0] pop_word;
    logic [4:0]  fill_count;
    logic        is_empty;
    logic        is_full;
    logic        last_reply;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic [WORD_W-1:0] word;
    logic [TICK_W-1:0] ticks;
    logic              zero_ticks;
  } cmd_t;

  // Back-end status, watched by checks at the top level
  typedef struct packed {
    logic             waiter_pending;
    logic [CNT_W-1:0] fill;
  } back_stat_t;

endpackage

// File: rtl/brq_front.sv
`timescale 1ns / 1ps

module brq_front import brq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_full,
  output cmd_t     cmd
);

  logic cmd_valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;

  assign in_stall  = cmd_valid_r && cmd_full;
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

  // Classify: keep low word bits, saturate the tick budget
  always_comb begin
    cmd_nxt.op   = in_data.req_type;
    cmd_nxt.word = in_data.push_word[WORD_W-1:0];
    if (in_data.wait_ticks > TICK_MAX) begin
      cmd_nxt.ticks = TICK_MAX[TICK_W-1:0];
    end else begin
      cmd_nxt.ticks = in_data.wait_ticks[TICK_W-1:0];
    end
    cmd_nxt.zero_ticks = (in_data.wait_ticks == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (accept) begin
      cmd_valid_r <= 1'b1;
    end else if (!cmd_full) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: rtl/brq_cmdq.sv
`timescale 1ns / 1ps

module brq_cmdq import brq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic full,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_pop,
  output cmd_t rd_cmd
);

  cmd_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;
  logic              pop;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = ent_r[rd_ptr_r];
  assign push     = wr_valid && !full;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: rtl/brq_back.sv
`timescale 1ns / 1ps

module brq_back import brq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  output back_stat_t stat
);

  logic [WORD_W-1:0] slot_r [CAPACITY];
  logic [CNT_W-1:0]  wc_r, wc_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic              pend_r, pend_nxt;
  logic [TICK_W-1:0] left_r, left_nxt;
  logic [TICK_W-1:0] left_dec;

  logic       out_valid_r;
  out_item_t  out_r;
  logic       sec_valid_r;
  out_item_t  sec_r;

  logic              load_ok;
  logic              take;
  logic              wr_en;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_after;
  logic [WORD_W-1:0] head_word;
  logic [1:0]        n_res;
  out_item_t         r0, r1;

  assign load_ok   = !out_valid_r || !out_stall;
  assign take      = q_valid && !sec_valid_r && load_ok;
  assign q_pop     = take;
  assign fill      = wc_r - rc_r;
  assign head_word = slot_r[rc_r[IDX_W-1:0]];
  assign left_dec  = (left_r != '0) ? left_r - 1'b1 : left_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign stat.waiter_pending = pend_r;
  assign stat.fill           = fill;

  // Execute one command against the ring state
  always_comb begin
    wc_nxt   = wc_r;
    rc_nxt   = rc_r;
    pend_nxt = pend_r;
    left_nxt = left_r;
    wr_en    = 1'b0;
    n_res    = 2'd0;
    r0       = '0;
    r1       = '0;
    unique case (q_cmd.op)
      REQ_PUSH: begin
        n_res       = 2'd1;
        r0.reply_to = REQ_PUSH;
        if (fill == FILL_FULL) begin
          r0.status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wc_nxt    = wc_r + 1'b1;
          r0.status = ST_OK;
          // Waiter present means the ring was empty: hand the word straight over
          if (pend_r) begin
            pend_nxt    = 1'b0;
            left_nxt    = '0;
            rc_nxt      = rc_r + 1'b1;
            n_res       = 2'd2;
            r1.reply_to = REQ_WAIT;
            r1.status   = ST_OK;
            r1.pop_word = 32'(q_cmd.word);
          end
        end
      end
      REQ_POP: begin
        n_res       = 2'd1;
        r0.reply_to = REQ_POP;
        if (fill == '0) begin
          r0.status = ST_EMPTY;
        end else begin
          r0.status   = ST_OK;
          r0.pop_word = 32'(head_word);
          rc_nxt      = rc_r + 1'b1;
        end
      end
      REQ_WAIT: begin
        r0.reply_to = REQ_WAIT;
        priority if (pend_r) begin
          n_res     = 2'd1;
          r0.status = ST_BUSY;
        end else if (fill != '0) begin
          n_res       = 2'd1;
          r0.status   = ST_OK;
          r0.pop_word = 32'(head_word);
          rc_nxt      = rc_r + 1'b1;
        end else if (q_cmd.zero_ticks) begin
          n_res     = 2'd1;
          r0.status = ST_TIMEOUT;
        end else begin
          pend_nxt = 1'b1;
          left_nxt = q_cmd.ticks;
        end
      end
      REQ_TICK: begin
        r0.reply_to = REQ_WAIT;
        r0.status   = ST_TIMEOUT;
        if (pend_r) begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            pend_nxt = 1'b0;
            n_res    = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    fill_after    = wc_nxt - rc_nxt;
    r0.fill_count = 5'(fill_after);
    r0.is_empty   = (fill_after == '0);
    r0.is_full    = (fill_after == FILL_FULL);
    r0.last_reply = (n_res == 2'd1);
    r1.fill_count = r0.fill_count;
    r1.is_empty   = r0.is_empty;
    r1.is_full    = r0.is_full;
    r1.last_reply = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= '0;
      rc_r        <= '0;
      pend_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      if (take) begin
        wc_r   <= wc_nxt;
        rc_r   <= rc_nxt;
        pend_r <= pend_nxt;
        left_r <= left_nxt;
      end
      if (load_ok) begin
        if (sec_valid_r) begin
          out_valid_r <= 1'b1;
          sec_valid_r <= 1'b0;
        end else if (take && n_res != 2'd0) begin
          out_valid_r <= 1'b1;
          sec_valid_r <= (n_res == 2'd2);
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      slot_r[wc_r[IDX_W-1:0]] <= q_cmd.word;
    end
    if (load_ok) begin
      if (sec_valid_r) begin
        out_r <= sec_r;
      end else if (take) begin
        out_r <= r0;
        sec_r <= r1;
      end
    end
  end

endmodule

// File: rtl/bounded_ring_queue_with_timed_wait_unit.sv
`timescale 1ns / 1ps
// Path from an accepted request to its first reply: the front register, then the
//   command queue, then the reply register.
// Throughput: one request per cycle while in_stall is low; a push that completes
//   a waiter holds the back end until its second reply enters the one reply register.
// Reset: rst_n synchronous, active low; clears counters, waiter and all valids.
//   Slot contents are not cleared and are only read after being written.

module bounded_ring_queue_with_timed_wait_unit import brq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Front: register and classify each incoming transaction
  logic       f_valid;
  cmd_t       f_cmd;
  logic       q_full;

  // Queue to back end
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;

  back_stat_t b_stat;

  brq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_full  (q_full),
    .cmd       (f_cmd)
  );

  // Short command queue: decouple front-end acceptance from back-end stalls
  brq_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .full     (q_full),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (q_cmd)
  );

  // Back: ring counters, slot store, the timed waiter and the reply registers
  brq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (b_stat)
  );

  // A pending waiter only exists while the ring is empty
  assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.waiter_pending |-> (b_stat.fill == '0))
    else $error("waiter pending with words in ring");

  // Fill never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.fill <= FILL_FULL)
    else $error("fill count beyond capacity");

  // Busy replies only answer wait-pops
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_BUSY) |-> (out_data.reply_to == REQ_WAIT))
    else $error("busy reply to non wait-pop");

  // A successful pop leaves the ring not full
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.reply_to == REQ_POP && out_data.status == ST_OK)
      |-> !out_data.is_full)
    else $error("full after successful pop");

endmodule

// File: dv/tb_bounded_ring_queue_with_timed_wait_unit.sv
`timescale 1ns / 1ps

module tb_bounded_ring_queue_with_timed_wait_unit;
  import brq_pkg::*;

  localparam int RANDOM_ITEMS = 1023;   // random requests after the directed opening
  localparam int SEGMENT_LEN  = 52;     // requests per traffic mix
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;

  // Traffic mixes: lean toward filling, draining, balance, or waiter play.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_WAITER} traffic_mix_e;

  // Image of the ring queue plus the replies it still owes.
  class ring_reply_board;
    logic [WORD_W-1:0] ring_words [CAPACITY];
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  rd_ptr;
    logic              waiter_armed;
    logic [TICK_W-1:0] waiter_budget;
    out_item_t         pending_replies [$];
    int                mismatches;
    int                replies_checked;
    int                status_hits [5];

    function new();
      wr_ptr          = '0;
      rd_ptr          = '0;
      waiter_armed    = 1'b0;
      waiter_budget   = '0;
      mismatches      = 0;
      replies_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function logic [CNT_W-1:0] held();
      return wr_ptr - rd_ptr;
    endfunction

    function logic [WORD_W-1:0] take_oldest();
      logic [WORD_W-1:0] w;
      w      = ring_words[rd_ptr[IDX_W-1:0]];
      rd_ptr = rd_ptr + 1'b1;
      return w;
    endfunction

    function out_item_t reply(logic [1:0] to, logic [2:0] st, logic [WORD_W-1:0] w);
      out_item_t r;
      r          = '0;
      r.reply_to = to;
      r.status   = st;
      r.pop_word = w;
      return r;
    endfunction

    // Advance the queue image by one accepted transaction, queue its replies.
    function void predict_replies(in_item_t req);
      out_item_t         replies [2];
      int                n;
      logic [TICK_W-1:0] budget;
      logic [CNT_W-1:0]  fill;
      n      = 0;
      budget = (req.wait_ticks > TICK_MAX) ? TICK_W'(TICK_MAX) : req.wait_ticks[TICK_W-1:0];
      case (req.req_type)
        REQ_PUSH: begin
          if (held() >= FILL_FULL) begin
            replies[n] = reply(REQ_PUSH, ST_FULL, '0);
            n++;
          end else begin
            ring_words[wr_ptr[IDX_W-1:0]] = req.push_word[WORD_W-1:0];
            wr_ptr     = wr_ptr + 1'b1;
            replies[n] = reply(REQ_PUSH, ST_OK, '0);
            n++;
            // a parked waiter takes the word just stored
            if (waiter_armed) begin
              waiter_armed  = 1'b0;
              waiter_budget = '0;
              replies[n]    = reply(REQ_WAIT, ST_OK, take_oldest());
              n++;
            end
          end
        end
        REQ_POP: begin
          if (held() == '0) replies[n] = reply(REQ_POP, ST_EMPTY, '0);
          else              replies[n] = reply(REQ_POP, ST_OK, take_oldest());
          n++;
        end
        REQ_WAIT: begin
          if (waiter_armed) begin
            replies[n] = reply(REQ_WAIT, ST_BUSY, '0);
            n++;
          end else if (held() != '0) begin
            replies[n] = reply(REQ_WAIT, ST_OK, take_oldest());
            n++;
          end else if (budget == '0) begin
            replies[n] = reply(REQ_WAIT, ST_TIMEOUT, '0);
            n++;
          end else begin
            waiter_armed  = 1'b1;
            waiter_budget = budget;
          end
        end
        REQ_TICK: begin
          if (waiter_armed) begin
            if (waiter_budget != '0) waiter_budget = waiter_budget - 1'b1;
            if (waiter_budget == '0) begin
              waiter_armed = 1'b0;
              replies[n]   = reply(REQ_WAIT, ST_TIMEOUT, '0);
              n++;
            end
          end
        end
      endcase
      // occupancy flags reflect the state after the whole step
      fill = held();
      for (int k = 0; k < n; k++) begin
        replies[k].fill_count = fill;
        replies[k].is_empty   = (fill == '0);
        replies[k].is_full    = (fill == FILL_FULL);
        replies[k].last_reply = (k == n - 1);
        pending_replies.push_back(replies[k]);
      end
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with nothing outstanding: reply_to %0d status %0d",
               got.reply_to, got.status);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (want.status < 5) status_hits[want.status]++;
      field_check("reply_to", want.reply_to, got.reply_to);
      field_check("status", want.status, got.status);
      field_check("pop_word", want.pop_word, got.pop_word);
      field_check("fill_count", want.fill_count, got.fill_count);
      field_check("is_empty", want.is_empty, got.is_empty);
      field_check("is_full", want.is_full, got.is_full);
      field_check("last_reply", want.last_reply, got.last_reply);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bit gaps_on     = 1'b1;
  bit stalls_on   = 1'b1;
  int cycle_count = 0;
  int requests_sent = 0;

  ring_reply_board board = new();

  bounded_ring_queue_with_timed_wait_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Drop the run if it hangs; a correct run finishes far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check every reply transaction against the oldest outstanding prediction.
  // Signals are read just after the edge, so they still hold pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_reply(out_data);
  end

  // Receiver back-pressure: random stall bursts. Finish a burst already started
  // even after stalls are switched off.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 18);
      end
    end
  end

  function automatic in_item_t pack_request(logic [1:0] op, logic [31:0] w, logic [15:0] t);
    in_item_t req;
    req.req_type   = op;
    req.push_word  = w;
    req.wait_ticks = t;
    return req;
  endfunction

  function automatic in_item_t make_request(traffic_mix_e mix);
    in_item_t req;
    int       roll;
    int       word_roll;
    int       tick_roll;
    roll      = $urandom_range(0, 99);
    word_roll = $urandom_range(0, 99);
    tick_roll = $urandom_range(0, 99);
    // Hit the all-zero and all-one words now and then; otherwise random bits.
    if (word_roll < 8)       req.push_word = '0;
    else if (word_roll < 16) req.push_word = '1;
    else                     req.push_word = $urandom;
    // Mostly short budgets so waiters expire; some huge ones that only a push
    // can end, which also lets later wait-pops see the busy answer.
    if (tick_roll < 10)      req.wait_ticks = '0;
    else if (tick_roll < 70) req.wait_ticks = 16'($urandom_range(1, 6));
    else if (tick_roll < 85) req.wait_ticks = 16'($urandom);
    else                     req.wait_ticks = '1;
    case (mix)
      MIX_FILL:   req.req_type = (roll < 65) ? REQ_PUSH : (roll < 85) ? REQ_POP :
                                 (roll < 93) ? REQ_WAIT : REQ_TICK;
      MIX_DRAIN:  req.req_type = (roll < 25) ? REQ_PUSH : (roll < 80) ? REQ_POP :
                                 (roll < 90) ? REQ_WAIT : REQ_TICK;
      MIX_EVEN:   req.req_type = (roll < 40) ? REQ_PUSH : (roll < 80) ? REQ_POP :
                                 (roll < 92) ? REQ_WAIT : REQ_TICK;
      MIX_WAITER: req.req_type = (roll < 15) ? REQ_PUSH : (roll < 25) ? REQ_POP :
                                 (roll < 55) ? REQ_WAIT : REQ_TICK;
    endcase
    return req;
  endfunction

  // Present one request and hold it until the block takes it. A sender gap
  // lowers valid at the edge that closed the previous transaction.
  task automatic send_request(input in_item_t req);
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    board.predict_replies(req);
    requests_sent++;
  endtask

  initial begin
    in_item_t     req;
    traffic_mix_e mix;
    int           counted;
    int           seg_done;
    bit           quiet;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty answers, zero-budget timeout, idle tick,
    // waiter expiry, busy waiter, push that completes a waiter, full ring.
    send_request(pack_request(REQ_POP,  32'h0, 16'h0));
    send_request(pack_request(REQ_WAIT, 32'h0, 16'h0));
    send_request(pack_request(REQ_TICK, 32'h0, 16'h0));
    send_request(pack_request(REQ_WAIT, 32'h0, 16'd2));
    send_request(pack_request(REQ_WAIT, 32'h0, 16'd5));
    send_request(pack_request(REQ_TICK, 32'h0, 16'h0));
    send_request(pack_request(REQ_TICK, 32'h0, 16'h0));
    send_request(pack_request(REQ_WAIT, 32'h0, 16'hFFFF));
    send_request(pack_request(REQ_PUSH, 32'hFFFF_FFFF, 16'h0));
    for (int i = 0; i < CAPACITY; i++)
      send_request(pack_request(REQ_PUSH, 32'h1357_9BDF * i, 16'h0));
    send_request(pack_request(REQ_PUSH, 32'hDEAD_BEEF, 16'h0));
    send_request(pack_request(REQ_WAIT, 32'h0, 16'd7));

    // Random traffic in segments, each with its own mix; some segments run
    // without idling, and the last two never idle.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mix       = traffic_mix_e'($urandom_range(0, 3));
      quiet     = (RANDOM_ITEMS - counted <= 2 * SEGMENT_LEN) || ($urandom_range(0, 3) == 0);
      gaps_on   = !quiet;
      stalls_on = !quiet;
      seg_done  = 0;
      while (seg_done < SEGMENT_LEN && counted < RANDOM_ITEMS) begin
        req = make_request(mix);
        counted++;
        seg_done++;
        send_request(req);
      end
    end

    // Release the input, let the outstanding replies drain, then hold a
    // little longer to catch any stray transaction.
    in_valid  <= 1'b0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d requests and checked %0d replies (ok %0d, full %0d, empty %0d,",
             requests_sent, board.replies_checked, board.status_hits[ST_OK],
             board.status_hits[ST_FULL], board.status_hits[ST_EMPTY]);
    $display("  timeout %0d, busy %0d) across fill, drain and waiter traffic.",
             board.status_hits[ST_TIMEOUT], board.status_hits[ST_BUSY]);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/brq_pkg.sv
rtl/brq_front.sv
rtl/brq_cmdq.sv
rtl/brq_back.sv
rtl/bounded_ring_queue_with_timed_wait_unit.sv
dv/tb_bounded_ring_queue_with_timed_wait_unit.sv
